@@ rtl/etpc_pkg.sv @@
// Package for the escape-time pixel colouring block: widths, register
// indexes, colour ring function. No dependencies.
package etpc_pkg;

  localparam int CfgAddrWidth = 6;
  localparam logic [2:0] RegXMin = 3'd0;
  localparam logic [2:0] RegYMin = 3'd1;
  localparam logic [2:0] RegXStep = 3'd2;
  localparam logic [2:0] RegYStep = 3'd3;
  localparam logic [2:0] RegMaxIter = 3'd4;

  localparam logic [31:0] InsideWord = 32'hFF00_0000;

  // Truncated HSV channel from a value given in eighths
  function automatic logic [7:0] ring_channel(input logic [11:0] eighths);
    logic [11:0] v;
    v = eighths >> 3;
    if (eighths == 12'd408 || eighths == 12'd816) begin
      v = v - 12'd1;
    end
    return v[7:0];
  endfunction

  // Colour ring entry for count mod 64 (red low byte, alpha 255)
  function automatic logic [31:0] ring_colour(input logic [5:0] k);
    logic [7:0] k3;
    logic [2:0] sector;
    logic [4:0] m;
    logic [11:0] m51;
    logic [7:0] p, q, t, r, g, b;
    k3 = 8'(k) * 8'd3;
    sector = k3[7:5];
    m = k3[4:0];
    m51 = 12'(m) * 12'd51;
    p = 8'd50;
    q = ring_channel(12'd2040 - m51);
    t = ring_channel(12'd408 + m51);
    unique case (sector)
      3'd0: begin r = 8'd255; g = t; b = p; end
      3'd1: begin r = q; g = 8'd255; b = p; end
      3'd2: begin r = p; g = 8'd255; b = t; end
      3'd3: begin r = p; g = q; b = 8'd255; end
      3'd4: begin r = t; g = p; b = 8'd255; end
      default: begin r = 8'd255; g = p; b = q; end
    endcase
    return {8'hFF, b, g, r};
  endfunction

endpackage

@@ rtl/etpc_front.sv @@
// Front part: accepts pixel coordinates, forms c, pushes into a two-entry queue.
// No package dependencies.
module etpc_front #(
  parameter int CW = 48,
  parameter int FB = 44,
  parameter int NB = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NB-1:0]       col,
  input  logic [NB-1:0]       row,
  input  logic signed [CW-1:0] x_min,
  input  logic signed [CW-1:0] y_min,
  input  logic [FB:0]         x_step,
  input  logic [FB:0]         y_step,
  output logic                q_valid,
  input  logic                q_pop,
  output logic signed [CW-1:0] q_cre,
  output logic signed [CW-1:0] q_cim
);
  localparam int PW = NB + FB + 1;
  localparam logic signed [CW+1:0] CMax = (CW+2)'((65'sd1 <<< (CW-1)) - 1);
  localparam logic signed [CW+1:0] CMin = -CMax - 1;

  // stage 1: products; stage 2: saturated sums into queue
  logic              s1_v_r;
  logic [PW-1:0]     px_r, py_r;
  logic signed [CW-1:0] qre_r [2];
  logic signed [CW-1:0] qim_r [2];
  logic [1:0]        cnt_r;
  logic              wp_r, rp_r;

  function automatic logic signed [CW-1:0] csum(input logic signed [CW-1:0] b,
                                               input logic [PW-1:0] p);
    logic signed [CW+1:0] off, s;
    off = (p > PW'(CMax)) ? CMax : (CW+2)'(p);
    s = (CW+2)'(b) + off;
    if (s > CMax) s = CMax;
    if (s < CMin) s = CMin;
    return s[CW-1:0];
  endfunction

  wire push = s1_v_r;
  // accept only when queue has room even counting the product in flight
  assign in_ready = (32'(cnt_r) + 32'(s1_v_r)) < 2;
  wire acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px_r <= PW'(col) * PW'(x_step);
      py_r <= PW'(row) * PW'(y_step);
    end
    if (push) begin
      qre_r[wp_r] <= csum(x_min, px_r);
      qim_r[wp_r] <= csum(y_min, py_r);
    end
  end

  assign q_valid = cnt_r != 2'd0;
  assign q_cre = qre_r[rp_r];
  assign q_cim = qim_r[rp_r];
endmodule

@@ rtl/etpc_back.sv @@
// Back part: iterates z = z*z + c with a four-phase split multiply, then colours
// the result into an output register. Depends on etpc_pkg.
module etpc_back #(
  parameter int CW = 48,
  parameter int FB = 44,
  parameter int IB = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic signed [CW-1:0] q_cre,
  input  logic signed [CW-1:0] q_cim,
  input  logic [IB-1:0]        max_iter,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IB-1:0]        out_count,
  output logic                 out_inside,
  output logic [31:0]          out_word
);
  localparam int MW = 2 * CW;
  localparam int SW = 67;
  localparam int H = (CW + 1) / 2;
  localparam logic [MW-1:0] CMaxU = MW'((65'd1 << (CW-1)) - 1);
  localparam logic [63:0] SqMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [64:0] Limit = 65'd4 << FB;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SUM = 5'b00010, S_MUL = 5'b00100, S_SQ = 5'b01000,
    S_OUT = 5'b10000
  } st_t;

  st_t st_r;
  logic signed [CW-1:0] cre_r, cim_r, x_r, y_r;
  logic [63:0] x2_r, y2_r;
  logic [MW-1:0] pxx_r, pyy_r, pxy_r;
  logic          neg_r;
  logic signed [CW+1:0] txy_r;
  logic [1:0]    ph_r;
  logic [IB-1:0] cnt_r;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] mx;
    mx = SW'(CMaxU);
    if (s > mx) return mx[CW-1:0];
    if (s < -mx - 1) return CW'(-mx - 1);
    return s[CW-1:0];
  endfunction

  // low or high half of a magnitude
  function automatic logic [H-1:0] half(input logic [CW-1:0] v, input logic hi);
    return hi ? H'(v >> H) : v[H-1:0];
  endfunction

  // one partial product of the split multiply, placed at its weight
  function automatic logic [MW-1:0] part(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                         input logic [1:0] ph);
    logic [2*H-1:0] pp;
    pp = (2*H)'(half(a, ph[1])) * (2*H)'(half(b, ph[0]));
    return MW'(pp) << ((ph[0] ? H : 0) + (ph[1] ? H : 0));
  endfunction

  wire [CW-1:0] xm = mag(x_r);
  wire [CW-1:0] ym = mag(y_r);

  // escape test on the squares of the current iterate
  wire [64:0] esc = 65'(x2_r) + 65'(y2_r);
  wire        run = (esc < Limit) && (cnt_r < max_iter);

  // squares shifted down by the fraction bits (saturated in S_SQ)
  wire [MW-1:0] xs = pxx_r >> FB;
  wire [MW-1:0] ys = pyy_r >> FB;
  // doubled product magnitude, rounded toward minus infinity when negative
  wire [MW-1:0] tq = pxy_r >> (FB-1);
  wire          tr = |(pxy_r & ((MW'(1) << (FB-1)) - 1));
  wire [MW:0]   tm = (MW+1)'(tq) + (MW+1)'(neg_r && tr);
  logic signed [CW+1:0] txy;
  always_comb begin
    if (!neg_r) txy = (tm > (MW+1)'(CMaxU)) ? (CW+2)'(CMaxU) : (CW+2)'(tm);
    else if (tm > (MW+1)'(CMaxU)) txy = -(CW+2)'(CMaxU) - 1;
    else txy = -(CW+2)'(tm);
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = st_r == S_OUT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) st_r <= S_SUM;
        S_SUM: st_r <= run ? S_MUL : S_OUT;
        S_MUL: if (ph_r == 2'd3) st_r <= S_SQ;
        S_SQ: st_r <= S_SUM;
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        cre_r <= q_cre;
        cim_r <= q_cim;
        x_r <= '0;
        y_r <= '0;
        x2_r <= '0;
        y2_r <= '0;
        cnt_r <= '0;
        pxx_r <= '0;
        pyy_r <= '0;
        pxy_r <= '0;
        neg_r <= 1'b0;
        txy_r <= '0;
        ph_r <= '0;
      end
      // one pass: update x, y from squares and product, or finish
      S_SUM: begin
        if (run) begin
          y_r <= sat(SW'(txy_r) + SW'(cim_r));
          x_r <= sat(SW'($signed({1'b0, x2_r})) - SW'($signed({1'b0, y2_r}))
                     + SW'(cre_r));
          cnt_r <= cnt_r + 1'b1;
          pxx_r <= '0;
          pyy_r <= '0;
          pxy_r <= '0;
        end else begin
          out_count <= cnt_r;
          out_inside <= cnt_r == max_iter;
          out_word <= (cnt_r == max_iter) ? etpc_pkg::InsideWord
                                          : etpc_pkg::ring_colour(cnt_r[5:0]);
        end
      end
      // accumulate one quarter of each product per cycle
      S_MUL: begin
        pxx_r <= pxx_r + part(xm, xm, ph_r);
        pyy_r <= pyy_r + part(ym, ym, ph_r);
        pxy_r <= pxy_r + part(xm, ym, ph_r);
        neg_r <= x_r[CW-1] ^ y_r[CW-1];
        ph_r <= ph_r + 2'd1;
      end
      // saturate squares and the doubled product for the next pass
      S_SQ: begin
        x2_r <= (xs > MW'(SqMax)) ? SqMax : 64'(xs);
        y2_r <= (ys > MW'(SqMax)) ? SqMax : 64'(ys);
        txy_r <= txy;
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/escape_time_pixel_colour_top.sv @@
// Escape-time pixel colouring top: config registers, front (c forming), back (iteration).
// Depends on etpc_pkg, etpc_front, etpc_back.
// The back part works on one pixel at a time and takes the next only after its result
// is accepted; each pass of its loop runs the split multiply phases, then square
// saturation, then the update.
// Reset (rst_n, synchronous, active low) loads register defaults and empties the queue.
module escape_time_pixel_colour_top #(
  parameter int COORD_WIDTH = 48,
  parameter int FRAC_BITS = 44,
  parameter int ITER_BITS = 12,
  parameter int INDEX_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2*INDEX_BITS-1:0] in_tdata,  // column, row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [((ITER_BITS+33+7)/8)*8-1:0] out_tdata, // iteration_count, inside_res, pixel_word
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [etpc_pkg::CfgAddrWidth-1:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int OW = ((ITER_BITS+33+7)/8)*8;
  logic signed [COORD_WIDTH-1:0] xmin_r, ymin_r;
  logic [FRAC_BITS:0] xstep_r, ystep_r;
  logic [ITER_BITS-1:0] maxit_r;
  wire [2:0] idx = cfg_paddr[etpc_pkg::CfgAddrWidth-1:3];
  wire wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:0] == 3'd0);

  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= COORD_WIDTH'(-64'sd43980465111040);
      ymin_r <= COORD_WIDTH'(-64'sd26388279066624);
      xstep_r <= (FRAC_BITS+1)'(64'd76965813944);
      ystep_r <= (FRAC_BITS+1)'(64'd87960930222);
      maxit_r <= ITER_BITS'(100);
    end else if (wr) begin
      unique case (idx)
        etpc_pkg::RegXMin: xmin_r <= cfg_pwdata[COORD_WIDTH-1:0];
        etpc_pkg::RegYMin: ymin_r <= cfg_pwdata[COORD_WIDTH-1:0];
        etpc_pkg::RegXStep: xstep_r <= cfg_pwdata[FRAC_BITS:0];
        etpc_pkg::RegYStep: ystep_r <= cfg_pwdata[FRAC_BITS:0];
        etpc_pkg::RegMaxIter: maxit_r <= cfg_pwdata[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (idx)
      etpc_pkg::RegXMin: cfg_prdata = 64'(xmin_r);
      etpc_pkg::RegYMin: cfg_prdata = 64'(ymin_r);
      etpc_pkg::RegXStep: cfg_prdata = 64'(xstep_r);
      etpc_pkg::RegYStep: cfg_prdata = 64'(ystep_r);
      etpc_pkg::RegMaxIter: cfg_prdata = 64'(maxit_r);
      default: cfg_prdata = '0;
    endcase
  end

  logic q_valid, q_pop;
  logic signed [COORD_WIDTH-1:0] q_cre, q_cim;
  logic [ITER_BITS-1:0] cnt;
  logic inside_flag;
  logic [31:0] word;

  etpc_front #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .NB(INDEX_BITS)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .col(in_tdata[INDEX_BITS-1:0]), .row(in_tdata[2*INDEX_BITS-1:INDEX_BITS]),
    .x_min(xmin_r), .y_min(ymin_r), .x_step(xstep_r), .y_step(ystep_r),
    .q_valid, .q_pop, .q_cre, .q_cim
  );

  etpc_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .IB(ITER_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cre, .q_cim, .max_iter(maxit_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_count(cnt), .out_inside(inside_flag), .out_word(word)
  );

  assign out_tdata = OW'({word, inside_flag, cnt});
endmodule
